// ----- rtl/slps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the status LED pattern sequencer.
// No dependencies; imported by status_led_pattern_sequencer_core.
package slps_pkg;

    typedef enum logic [2:0] {
        MODE_RAINBOW    = 3'd0,
        MODE_YELLOW     = 3'd1,
        MODE_BREATHE    = 3'd2,
        MODE_GREEN_FAST = 3'd3,
        MODE_FLASH      = 3'd4,
        MODE_RED_SLOW   = 3'd5,
        MODE_RED_SOLID  = 3'd6
    } mode_t;

    // Mode code with no meaning; a write of it is dropped
    localparam logic [2:0] MODE_CODE_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        FLASH_IDLE = 2'd0,
        FLASH_LIT  = 2'd1,
        FLASH_DARK = 2'd2
    } flash_phase_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_MODE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        CFG_BREATHE_FLOOR   = 2'd0,
        CFG_BREATHE_CEILING = 2'd1,
        CFG_BREATHE_INCR    = 2'd2,
        CFG_BREATHE_PERIOD  = 2'd3
    } cfg_index_t;

    localparam int WAIT_W  = 10;
    localparam int HUE_W   = 9;
    localparam int LEVEL_W = 8;
    localparam int INCR_W  = 7;
    localparam int CFG_W   = 10;

    localparam logic [HUE_W-1:0]   HUE_WRAP = 9'd360;
    localparam logic [HUE_W-1:0]   HUE_STEP = 9'd5;

    // Reload values are the step interval minus one
    localparam logic [WAIT_W-1:0] WAIT_RAINBOW = 10'd19;
    localparam logic [WAIT_W-1:0] WAIT_YELLOW  = 10'd249;
    localparam logic [WAIT_W-1:0] WAIT_GREEN   = 10'd79;
    localparam logic [WAIT_W-1:0] WAIT_RED     = 10'd499;
    localparam logic [WAIT_W-1:0] WAIT_FLASH   = 10'd49;

    localparam logic [7:0] LVL_DIM  = 8'd100;
    localparam logic [7:0] LVL_MID  = 8'd150;
    localparam logic [7:0] LVL_FULL = 8'd255;

    localparam logic [7:0]        RST_FLOOR   = 8'd5;
    localparam logic [7:0]        RST_CEILING = 8'd180;
    localparam logic [INCR_W-1:0] RST_INCR    = 7'd3;
    localparam logic [WAIT_W-1:0] RST_PERIOD  = 10'd30;

    typedef struct packed {
        logic             use_hsv;
        logic [HUE_W-1:0] hue;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } pixel_t;

endpackage

// ----- rtl/status_led_pattern_sequencer_core.sv -----
`timescale 1ns / 1ps
// A tick that triggers a step shows its pixel on m_* in the cycle after acceptance.
// Throughput: one item per cycle; s_ready drops only while a pixel waits on m_ready.
// The output register decouples the sides, so an item is taken while a pixel waits if m_ready.
// Reset (aresetn low, synchronous): rainbow mode, no flash, wait 0, hue 0, breathe level 0
// rising, blink lit, breathe registers at 5/180/3/30 and no pixel pending.
// Uses slps_pkg for mode codes, register indexes and the pixel type.
module status_led_pattern_sequencer_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  slps_pkg::cfg_index_t       cfg_addr,
    input  logic [slps_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [2:0]                 s_mode,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_use_hsv,
    output logic [slps_pkg::HUE_W-1:0] m_hue,
    output logic [7:0]                 m_red,
    output logic [7:0]                 m_green,
    output logic [7:0]                 m_blue
);
    import slps_pkg::*;

    logic [7:0]         floor_reg;
    logic [7:0]         ceiling_reg;
    logic [INCR_W-1:0]  incr_reg;
    logic [WAIT_W-1:0]  period_reg;

    mode_t              active_mode_reg, active_mode_next;
    mode_t              resume_mode_reg, resume_mode_next;
    flash_phase_t       flash_phase_reg, flash_phase_next;
    logic [WAIT_W-1:0]  wait_left_reg, wait_left_next;
    logic [HUE_W-1:0]   hue_now_reg, hue_now_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               breathe_up_reg, breathe_up_next;
    logic               blink_lit_reg, blink_lit_next;

    logic               m_valid_reg, m_valid_next;
    pixel_t             pixel_reg, pixel_next;

    logic               s_accept;
    logic               produce;
    mode_t              step_mode;
    logic [HUE_W-1:0]   hue_sum;
    logic signed [9:0]  lvl;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign m_valid   = m_valid_reg;
    assign m_use_hsv = pixel_reg.use_hsv;
    assign m_hue     = pixel_reg.hue;
    assign m_red     = pixel_reg.red;
    assign m_green   = pixel_reg.green;
    assign m_blue    = pixel_reg.blue;

    // A step right after the dark flash phase runs the resumed mode
    assign step_mode = (flash_phase_reg != FLASH_IDLE) ? resume_mode_reg : active_mode_reg;
    assign hue_sum   = hue_now_reg + HUE_STEP;
    assign lvl = breathe_up_reg
               ? $signed({2'b00, level_reg}) + $signed({3'b000, incr_reg})
               : $signed({2'b00, level_reg}) - $signed({3'b000, incr_reg});

    always_comb begin
        active_mode_next = active_mode_reg;
        resume_mode_next = resume_mode_reg;
        flash_phase_next = flash_phase_reg;
        wait_left_next   = wait_left_reg;
        hue_now_next     = hue_now_reg;
        level_next       = level_reg;
        breathe_up_next  = breathe_up_reg;
        blink_lit_next   = blink_lit_reg;
        produce          = 1'b0;
        pixel_next       = '0;

        if (s_accept) begin
            if (kind_t'(s_kind) == KIND_MODE) begin
                if (s_mode != MODE_CODE_UNUSED) begin
                    if (mode_t'(s_mode) == MODE_FLASH && active_mode_reg != MODE_FLASH) begin
                        resume_mode_next = active_mode_reg;
                    end
                    active_mode_next = mode_t'(s_mode);
                end
            end else if (wait_left_reg != '0) begin
                wait_left_next = wait_left_reg - 1'b1;
            end else begin
                produce = 1'b1;
                if (flash_phase_reg == FLASH_LIT) begin
                    flash_phase_next = FLASH_DARK;
                    wait_left_next   = WAIT_FLASH;
                end else begin
                    if (flash_phase_reg != FLASH_IDLE) begin
                        flash_phase_next = FLASH_IDLE;
                        active_mode_next = resume_mode_reg;
                    end
                    unique case (step_mode)
                        MODE_RAINBOW: begin
                            pixel_next.use_hsv = 1'b1;
                            pixel_next.hue     = hue_now_reg;
                            hue_now_next = (hue_sum >= HUE_WRAP) ? hue_sum - HUE_WRAP : hue_sum;
                            wait_left_next = WAIT_RAINBOW;
                        end
                        MODE_YELLOW: begin
                            blink_lit_next = !blink_lit_reg;
                            if (!blink_lit_reg) begin
                                pixel_next.red   = LVL_DIM;
                                pixel_next.green = LVL_DIM;
                            end
                            wait_left_next = WAIT_YELLOW;
                        end
                        MODE_BREATHE: begin
                            // Ceiling check wins when the bounds cross
                            if (lvl >= $signed({2'b00, ceiling_reg})) begin
                                level_next      = ceiling_reg;
                                breathe_up_next = 1'b0;
                            end else if (lvl <= $signed({2'b00, floor_reg})) begin
                                level_next      = floor_reg;
                                breathe_up_next = 1'b1;
                            end else begin
                                level_next = lvl[LEVEL_W-1:0];
                            end
                            pixel_next.green = level_next;
                            wait_left_next   = (period_reg == '0) ? '0 : period_reg - 1'b1;
                        end
                        MODE_GREEN_FAST: begin
                            blink_lit_next = !blink_lit_reg;
                            if (!blink_lit_reg) begin
                                pixel_next.green = LVL_MID;
                            end
                            wait_left_next = WAIT_GREEN;
                        end
                        MODE_FLASH: begin
                            pixel_next.green = LVL_FULL;
                            flash_phase_next = FLASH_LIT;
                            wait_left_next   = WAIT_FLASH;
                        end
                        MODE_RED_SLOW: begin
                            blink_lit_next = !blink_lit_reg;
                            if (!blink_lit_reg) begin
                                pixel_next.red = LVL_DIM;
                            end
                            wait_left_next = WAIT_RED;
                        end
                        default: begin
                            pixel_next.red = LVL_FULL;
                            wait_left_next = WAIT_RED;
                        end
                    endcase
                end
            end
        end

        if (produce) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg       <= RST_FLOOR;
            ceiling_reg     <= RST_CEILING;
            incr_reg        <= RST_INCR;
            period_reg      <= RST_PERIOD;
            active_mode_reg <= MODE_RAINBOW;
            resume_mode_reg <= MODE_RAINBOW;
            flash_phase_reg <= FLASH_IDLE;
            wait_left_reg   <= '0;
            hue_now_reg     <= '0;
            level_reg       <= '0;
            breathe_up_reg  <= 1'b1;
            blink_lit_reg   <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_BREATHE_FLOOR:   floor_reg   <= cfg_wdata[7:0];
                    CFG_BREATHE_CEILING: ceiling_reg <= cfg_wdata[7:0];
                    CFG_BREATHE_INCR:    incr_reg    <= cfg_wdata[INCR_W-1:0];
                    CFG_BREATHE_PERIOD:  period_reg  <= cfg_wdata[WAIT_W-1:0];
                    default: ;
                endcase
            end
            active_mode_reg <= active_mode_next;
            resume_mode_reg <= resume_mode_next;
            flash_phase_reg <= flash_phase_next;
            wait_left_reg   <= wait_left_next;
            hue_now_reg     <= hue_now_next;
            level_reg       <= level_next;
            breathe_up_reg  <= breathe_up_next;
            blink_lit_reg   <= blink_lit_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload register loads only with a new pixel
    always_ff @(posedge aclk) begin
        if (produce) begin
            pixel_reg <= pixel_next;
        end
    end

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hue_now_reg < HUE_WRAP)
        else $error("hue left its range");

    a_hsv_rgb_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && pixel_reg.use_hsv) |->
            (pixel_reg.red == '0 && pixel_reg.green == '0 && pixel_reg.blue == '0))
        else $error("hue pixel carries rgb levels");

    a_mode_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_kind == KIND_MODE && !m_valid_reg) |=> !m_valid_reg)
        else $error("mode write produced a pixel");

    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_kind == KIND_TICK && wait_left_reg != '0) |=>
            (wait_left_reg == $past(wait_left_reg) - 1'b1))
        else $error("idle tick did not count down");

    a_flash_dark_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && flash_phase_reg == FLASH_LIT) |=>
            (flash_phase_reg == FLASH_DARK && wait_left_reg == WAIT_FLASH))
        else $error("flash dark phase not entered");

endmodule
